// File: rtl/domq_pkg.sv
// domq_pkg: shared types and constants of the deadline-ordered message queue
// no dependencies
`default_nettype none
package domq_pkg;
  localparam int TimeW = 48;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic [2:0] FuncPost     = 3'd0;
  localparam logic [2:0] FuncDebounce = 3'd1;
  localparam logic [2:0] FuncRemove   = 3'd2;
  localparam logic [2:0] FuncContains = 3'd3;
  localparam logic [2:0] FuncTick     = 3'd4;

  localparam logic [1:0] KindDispatch = 2'd0;
  localparam logic [1:0] KindRemove   = 2'd1;
  localparam logic [1:0] KindContains = 2'd2;
  localparam logic [1:0] KindPostAck  = 2'd3;

  // one stored message
  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [15:0]      target;
    logic [15:0]      mtype;
    logic [31:0]      handle;
  } entry_t;

  // one result word
  typedef struct packed {
    logic        last;
    logic        queue_full;
    logic        became_head;
    logic        found;
    logic [4:0]  removed_count;
    logic [31:0] out_handle;
    logic [15:0] out_type;
    logic [15:0] out_target;
    logic [1:0]  result_kind;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/deadline_ordered_message_queue_core.sv
// deadline_ordered_message_queue_core: sorted timer queue over one entry memory
// remove/contains scan all n stored entries; post scans the p entries ahead of the
// slot and moves the m entries behind it up, with no move when the table is full;
// debounce first removes every entry of the same target and type; tick dispatches
// due messages from the head, then moves the rest down; one word in flight at a time
// reset: asynchronous active low; clock is 1 and the table empty after reset
`default_nettype none
module deadline_ordered_message_queue_core
  import domq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: target_id, msg_type, match_any_type, delay_ms, message_handle, elapsed_ms
  input  wire logic [119:0] s_axis_tdata,
  // tuser: func
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: out_target, out_type, out_handle, removed_count, found, became_head, queue_full
  output logic [71:0]       m_axis_tdata,
  // tuser: result_kind
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  localparam int AddrW = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SEval = 3'd2;
  localparam logic [2:0] SIns  = 3'd3;
  localparam logic [2:0] SShW  = 3'd4;
  localparam logic [2:0] SComp = 3'd5;

  // operations of the scan loop
  localparam logic [1:0] OpMatch = 2'd0;
  localparam logic [1:0] OpFind  = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;

  logic [2:0]       state_q, state_d;
  logic [1:0]       op_q, op_d;
  logic [2:0]       func_q, func_d;
  logic [15:0]      tgt_q, tgt_d, typ_q, typ_d;
  logic             any_q, any_d;
  logic [31:0]      hnd_q, hnd_d;
  logic [TimeW-1:0] clock_q, clock_d, dl_q, dl_d;
  logic [CntW-1:0]  count_q, count_d, idx_q, idx_d, wr_q, wr_d, rem_q, rem_d;
  logic             found_q, found_d;
  entry_t           carry_q, carry_d;
  logic             ovalid_q, ovalid_d;
  result_t          ores_q, ores_d;
  logic             pend_q, pend_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  entry_t           wdata, rdata;

  domq_mem #(.Depth(QUEUE_DEPTH), .AddrW(AddrW)) u_mem (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [TimeW:0] dl_sum, clk_sum;
  assign dl_sum  = {1'b0, clock_q} + {17'd0, s_axis_tdata[64:33]};
  assign clk_sum = {1'b0, clock_q} + {33'd0, s_axis_tdata[112:97]};

  logic match;
  assign match = (rdata.target == tgt_q) &&
                 (any_q || (rdata.mtype == typ_q));

  assign s_axis_tready = (state_q == SIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ores_q.result_kind;
  assign m_axis_tlast  = ores_q.last;
  assign m_axis_tdata  = {ores_q.queue_full, ores_q.became_head, ores_q.found,
                          ores_q.removed_count, ores_q.out_handle,
                          ores_q.out_type, ores_q.out_target};

  always_comb begin
    state_d = state_q; op_d = op_q; func_d = func_q; tgt_d = tgt_q; typ_d = typ_q;
    any_d = any_q; hnd_d = hnd_q; clock_d = clock_q; dl_d = dl_q;
    count_d = count_q; idx_d = idx_q; wr_d = wr_q; rem_d = rem_q;
    found_d = found_q; carry_d = carry_q; ovalid_d = ovalid_q; ores_d = ores_q;
    pend_d = pend_q;
    we = 1'b0; waddr = wr_q[AddrW-1:0]; wdata = rdata;
    raddr = idx_q[AddrW-1:0];
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          func_d = s_axis_tuser;
          tgt_d = s_axis_tdata[15:0];
          typ_d = s_axis_tdata[31:16];
          any_d = s_axis_tdata[32];
          hnd_d = s_axis_tdata[96:65];
          dl_d  = dl_sum[TimeW] ? TimeMax : dl_sum[TimeW-1:0];
          idx_d = '0; wr_d = '0; rem_d = '0; found_d = 1'b0;
          case (s_axis_tuser)
            FuncPost: begin op_d = OpFind; state_d = SRead; end
            FuncDebounce: begin
              op_d = OpMatch; any_d = 1'b0; state_d = SRead;
            end
            FuncRemove, FuncContains: begin op_d = OpMatch; state_d = SRead; end
            FuncTick: begin
              clock_d = clk_sum[TimeW] ? TimeMax : clk_sum[TimeW-1:0];
              op_d = OpTick; state_d = SRead;
            end
            default: state_d = SIdle;
          endcase
        end
      end
      SRead: begin
        // raddr = idx_q; data valid next cycle
        state_d = SEval;
      end
      SEval: begin
        case (op_q)
          OpMatch: begin
            if (idx_q >= count_q) begin
              if (func_q == FuncContains) begin
                ores_d = '0; ores_d.result_kind = KindContains;
                ores_d.found = found_q; ores_d.last = 1'b1;
                ovalid_d = 1'b1; state_d = SIdle;
              end else begin
                count_d = wr_q;
                if (func_q == FuncDebounce) begin
                  op_d = OpFind; idx_d = '0; state_d = SRead;
                end else begin
                  ores_d = '0; ores_d.result_kind = KindRemove;
                  ores_d.removed_count = 5'(rem_q); ores_d.last = 1'b1;
                  ovalid_d = 1'b1; state_d = SIdle;
                end
              end
            end else begin
              if (func_q == FuncContains) begin
                found_d = found_q | match;
              end else if (match) begin
                rem_d = rem_q + 1'b1;
              end else begin
                // compact survivors down
                we = 1'b1; wr_d = wr_q + 1'b1;
              end
              idx_d = idx_q + 1'b1; state_d = SRead;
            end
          end
          OpFind: begin
            if (idx_q < count_q && rdata.deadline <= dl_q) begin
              idx_d = idx_q + 1'b1; state_d = SRead;
            end else begin
              state_d = SIns;
            end
          end
          OpTick: begin
            if (pend_q) begin
              // rdata is the entry after the staged one
              ores_d.last = (idx_q >= count_q) || (rdata.deadline > clock_q);
              ovalid_d = 1'b1; pend_d = 1'b0;
            end else if (idx_q >= count_q) begin
              count_d = '0; state_d = SIdle;
            end else if (rdata.deadline <= clock_q) begin
              if (!ovalid_q || m_axis_tready) begin
                ores_d = '0; ores_d.result_kind = KindDispatch;
                ores_d.out_target = rdata.target; ores_d.out_type = rdata.mtype;
                ores_d.out_handle = rdata.handle;
                pend_d = 1'b1; idx_d = idx_q + 1'b1; state_d = SRead;
              end
            end else if (idx_q == '0) begin
              state_d = SIdle;
            end else begin
              wr_d = '0; state_d = SComp;
            end
          end
          default: state_d = SIdle;
        endcase
      end
      SIns: begin
        ores_d = '0; ores_d.result_kind = KindPostAck;
        ores_d.removed_count = 5'(rem_q); ores_d.last = 1'b1;
        if (count_q >= CntW'(QUEUE_DEPTH)) begin
          ores_d.queue_full = 1'b1; ovalid_d = 1'b1; state_d = SIdle;
        end else begin
          ores_d.became_head = (idx_q == '0);
          carry_d = '{deadline: dl_q, target: tgt_q, mtype: typ_q, handle: hnd_q};
          wr_d = idx_q; count_d = count_q + 1'b1; state_d = SShW;
        end
      end
      SShW: begin
        // rdata holds old entry at wr_q; write carry there
        we = 1'b1; wdata = carry_q; carry_d = rdata;
        wr_d = wr_q + 1'b1; raddr = wr_q[AddrW-1:0] + 1'b1;
        if (wr_q + 1'b1 >= count_q) begin
          ovalid_d = 1'b1; state_d = SIdle;
        end
      end
      SComp: begin
        // slide kept entries to the base, one per cycle
        we = 1'b1; wdata = rdata; wr_d = wr_q + 1'b1; idx_d = idx_q + 1'b1;
        raddr = idx_q[AddrW-1:0] + 1'b1;
        if (idx_q + 1'b1 >= count_q) begin
          count_d = wr_q + 1'b1; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; op_q <= OpMatch; clock_q <= TimeW'(1);
      count_q <= '0; ovalid_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d; op_q <= op_d; clock_q <= clock_d;
      count_q <= count_d; ovalid_q <= ovalid_d; pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; tgt_q <= tgt_d; typ_q <= typ_d; any_q <= any_d;
    hnd_q <= hnd_d; dl_q <= dl_d; idx_q <= idx_d; wr_q <= wr_d;
    rem_q <= rem_d; found_q <= found_d; carry_q <= carry_d; ores_q <= ores_d;
  end
endmodule
`default_nettype wire

// File: rtl/domq_mem.sv
// domq_mem: entry table, one write port and one registered read port
// depends on domq_pkg
`default_nettype none
module domq_mem
  import domq_pkg::*;
#(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output entry_t                rdata_o
);
  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: tb/testbench.sv
// testbench: checks deadline_ordered_message_queue_core against a built-in
// model of the sorted timer queue; directed table then random traffic
// depends on domq_pkg and the core rtl
`timescale 1ns / 1ps
module testbench
  import domq_pkg::*;
();

  localparam int Depth = 16;
  localparam int NumRandom = 414;
  localparam longint CycleLimit = 2000000;
  localparam logic [2:0] FuncUnusedLo = 3'd5;
  localparam logic [2:0] FuncUnusedHi = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] target;
    logic [15:0] mtype;
    logic        any;
    logic [31:0] delay;
    logic [31:0] handle;
    logic [15:0] elapsed;
  } msg_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target;
    logic [15:0] mtype;
    logic [31:0] handle;
    logic [4:0]  removed;
    logic        found;
    logic        head;
    logic        full;
    logic        last;
  } msg_res_t;

  typedef struct {
    msg_cmd_t cmd;
    logic     has_fixed;
    msg_res_t fixed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  deadline_ordered_message_queue_core #(.QUEUE_DEPTH(Depth)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // model state
  logic [TimeW-1:0] now_ms;
  entry_t           timers[Depth];
  int               n_timers;
  msg_res_t         pending_results[$];
  row_t             rows[$];
  int               n_bad = 0;
  longint           cycles = 0;
  logic             hold_off = 1'b0;

  function automatic msg_res_t blank_res(logic [1:0] kind);
    msg_res_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_result(msg_res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic bit hit(int i, msg_cmd_t c, bit any);
    return timers[i].target == c.target && (any || timers[i].mtype == c.mtype);
  endfunction

  function automatic void drop_timer(int i);
    for (int j = i; j + 1 < n_timers; j++) timers[j] = timers[j + 1];
    n_timers--;
  endfunction

  function automatic int purge_timers(msg_cmd_t c, bit any);
    int i, n;
    i = 0;
    n = 0;
    while (i < n_timers) begin
      if (hit(i, c, any)) begin
        drop_timer(i);
        n++;
      end else begin
        i++;
      end
    end
    return n;
  endfunction

  // applies one command to the model and queues what the core should return
  function automatic void predict_queue(msg_cmd_t c);
    msg_res_t r;
    logic [TimeW:0] sum;
    logic [TimeW-1:0] dl;
    int pos;
    case (c.func)
      FuncPost, FuncDebounce: begin
        r = blank_res(KindPostAck);
        if (c.func == FuncDebounce) r.removed = 5'(purge_timers(c, 1'b0));
        sum = {1'b0, now_ms} + {17'd0, c.delay};
        dl = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
        if (n_timers >= Depth) begin
          r.full = 1'b1;
        end else begin
          pos = 0;
          while (pos < n_timers && timers[pos].deadline <= dl) pos++;
          for (int j = n_timers; j > pos; j--) timers[j] = timers[j - 1];
          timers[pos] = '{deadline: dl, target: c.target, mtype: c.mtype, handle: c.handle};
          n_timers++;
          r.head = (pos == 0);
        end
        add_result(r);
      end
      FuncRemove: begin
        r = blank_res(KindRemove);
        r.removed = 5'(purge_timers(c, c.any));
        add_result(r);
      end
      FuncContains: begin
        r = blank_res(KindContains);
        for (int i = 0; i < n_timers; i++) if (hit(i, c, c.any)) r.found = 1'b1;
        add_result(r);
      end
      FuncTick: begin
        sum = {1'b0, now_ms} + {33'd0, c.elapsed};
        now_ms = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
        while (n_timers > 0 && timers[0].deadline <= now_ms) begin
          r = blank_res(KindDispatch);
          r.target = timers[0].target;
          r.mtype = timers[0].mtype;
          r.handle = timers[0].handle;
          r.last = (n_timers == 1) || (timers[1].deadline > now_ms);
          add_result(r);
          drop_timer(0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic msg_cmd_t mk(logic [2:0] f, logic [15:0] t, logic [15:0] ty,
                                  logic a, logic [31:0] d, logic [31:0] h,
                                  logic [15:0] e);
    msg_cmd_t c;
    c = '{func: f, target: t, mtype: ty, any: a, delay: d, handle: h, elapsed: e};
    return c;
  endfunction

  function automatic void add_row(msg_cmd_t c, logic has_fixed, msg_res_t fixed);
    row_t rw;
    rw.cmd = c;
    rw.has_fixed = has_fixed;
    rw.fixed = fixed;
    rows.insert(rows.size(), rw);
  endfunction

  // sender; valid stays up between words offered back to back
  task automatic send_word(msg_cmd_t c, bit do_gap);
    int gap;
    gap = do_gap ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.func;
    s_axis_tdata <= {7'd0, c.elapsed, c.handle, c.delay, c.any, c.mtype, c.target};
    predict_queue(c);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic msg_cmd_t rand_cmd();
    msg_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.target = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    c.mtype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    c.any = 1'($urandom_range(0, 1));
    c.handle = $urandom;
    case ($urandom_range(0, 9))
      0: c.delay = $urandom;
      1: c.delay = 32'hFFFF_FFFF;
      default: c.delay = $urandom_range(0, 200);
    endcase
    c.elapsed = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
    if (sel < 35) c.func = FuncPost;
    else if (sel < 50) c.func = FuncDebounce;
    else if (sel < 62) c.func = FuncRemove;
    else if (sel < 72) c.func = FuncContains;
    else if (sel < 97) c.func = FuncTick;
    else c.func = 3'($urandom_range(FuncUnusedLo, FuncUnusedHi));
    return c;
  endfunction

  // receiver; ready stays up between words taken back to back
  initial begin
    int stall;
    msg_res_t got, want;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0 || hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = '{kind: m_axis_tuser, target: m_axis_tdata[15:0], mtype: m_axis_tdata[31:16],
              handle: m_axis_tdata[63:32], removed: m_axis_tdata[68:64],
              found: m_axis_tdata[69], head: m_axis_tdata[70], full: m_axis_tdata[71],
              last: m_axis_tlast};
      if (pending_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected word %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch: expected kind %0d tgt %h typ %h hnd %h rem %0d",
                     want.kind, want.target, want.mtype, want.handle, want.removed);
            $display("  fnd %b head %b full %b last %b",
                     want.found, want.head, want.full, want.last);
            $display("  got kind %0d tgt %h typ %h hnd %h rem %0d",
                     got.kind, got.target, got.mtype, got.handle, got.removed);
            $display("  fnd %b head %b full %b last %b",
                     got.found, got.head, got.full, got.last);
          end
        end
      end
    end
  end

  // long receiver hold-off so a result word waits and the input stalls
  initial begin
    @(posedge rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (1500) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t rw;
    msg_res_t r;
    now_ms = 1;
    n_timers = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    r = blank_res(KindContains);
    add_row(mk(FuncContains, 16'h0, 16'h0, 1'b1, 32'd0, 32'd0, 16'd0), 1'b1, r);
    r = blank_res(KindRemove);
    add_row(mk(FuncRemove, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 32'd0, 16'd0), 1'b1, r);
    r = blank_res(KindPostAck); r.head = 1'b1;
    add_row(mk(FuncPost, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, '1, 16'd0), 1'b1, r);
    add_row(mk(FuncPost, 16'h0, 16'h0, 1'b0, 32'd0, 32'd0, 16'd0), 1'b0, r);
    add_row(mk(FuncPost, 16'h5, 16'h7, 1'b0, 32'd10, 32'h1234_5678, 16'd0), 1'b0, r);
    add_row(mk(FuncPost, 16'h5, 16'h8, 1'b0, 32'd10, 32'hA5A5_A5A5, 16'd0), 1'b0, r);
    add_row(mk(FuncContains, 16'h5, 16'h9, 1'b1, 32'd0, 32'd0, 16'd0), 1'b0, r);
    add_row(mk(FuncContains, 16'h5, 16'h9, 1'b0, 32'd0, 32'd0, 16'd0), 1'b0, r);
    add_row(mk(FuncDebounce, 16'h5, 16'h7, 1'b1, 32'd5, 32'h5A5A_5A5A, 16'd0), 1'b0, r);
    add_row(mk(FuncTick, 16'h0, 16'h0, 1'b0, 32'd0, 32'd0, 16'h0), 1'b0, r);
    add_row(mk(FuncUnusedLo, '1, '1, 1'b1, '1, '1, '1), 1'b0, r);
    add_row(mk(FuncUnusedHi, 16'h0, 16'h0, 1'b0, 32'd0, 32'd0, 16'd0), 1'b0, r);
    add_row(mk(FuncTick, 16'h0, 16'h0, 1'b0, 32'd0, 32'd0, 16'd20), 1'b0, r);
    add_row(mk(FuncRemove, 16'h5, 16'h0, 1'b1, 32'd0, 32'd0, 16'd0), 1'b0, r);
    // one entry is left, so the last two posts find the table full
    r = blank_res(KindPostAck); r.full = 1'b1;
    for (int i = 0; i < 17; i++)
      add_row(mk(FuncPost, 16'(i), 16'h3, 1'b0, 32'(i % 3), 32'(i), 16'd0), i >= 15, r);
    add_row(mk(FuncRemove, 16'h2, 16'h3, 1'b0, 32'd0, 32'd0, 16'd0), 1'b0, r);
    for (int i = 0; i < 4; i++)
      add_row(mk(FuncTick, 16'h0, 16'h0, 1'b0, 32'd0, 32'd0, 16'hFFFF), 1'b0, r);

    foreach (rows[i]) begin
      rw = rows[i];
      send_word(rw.cmd, 1'b1);
      if (rw.has_fixed && pending_results[$] !== rw.fixed) begin
        n_bad++;
        if (n_bad <= 10) $display("table row %0d: model disagrees with typed result", i);
      end
    end
    // sender waits for every result before the random part
    wait_drained();

    for (int i = 0; i < NumRandom; i++) begin
      send_word(rand_cmd(), $urandom_range(0, 3) != 0);
      if (i == 200) wait_drained();
    end
    wait_drained();
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
